// ===== sv/sample_clock_timestamp_tracker_unit_defines.svh =====
// assertion macros for the sample clock timestamp tracker
`ifndef SAMPLE_CLOCK_TIMESTAMP_TRACKER_UNIT_DEFINES_SVH
`define SAMPLE_CLOCK_TIMESTAMP_TRACKER_UNIT_DEFINES_SVH

// property checked on every clock edge outside reset
`define SCTT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define SCTT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/sctt_pkg.sv =====
// shared types and constants for the sample clock timestamp tracker
`timescale 1ns / 1ps

package sctt_pkg;

    localparam int DEF_WINDOW = 8;

    localparam int SAMPLE_W = 48;
    localparam int TIME_W   = 64;
    localparam int SLOPE_W  = 40;
    localparam int ERR_W    = 48;
    localparam int LOOK_W   = 32;
    localparam int GAIN_W   = 17;
    localparam int EPOCH_W  = 16;
    localparam int OUT_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 40;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 48;

    localparam logic [SLOPE_W-1:0] NOMINAL_RST = 40'd89478485333;
    localparam logic [LOOK_W-1:0]  LOOK_RST    = 32'd5000;
    localparam logic [GAIN_W-1:0]  GAIN_RST    = 17'd6554;
    localparam logic [SLOPE_W-1:0] SLEW_RST    = 40'd10737418;
    localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'd65536;
    localparam logic [15:0]        ROUND_HALF  = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW    = 2'd3;

    localparam logic [OUT_W-1:0] OUT_REJECT = 2'd0;
    localparam logic [OUT_W-1:0] OUT_ANCHOR = 2'd1;
    localparam logic [OUT_W-1:0] OUT_DISC   = 2'd2;
    localparam logic [OUT_W-1:0] OUT_CONT   = 2'd3;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } div_req_t;

endpackage

// ===== sv/sctt_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module sctt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/sctt_mul.sv =====
// shared registered multiplier
`timescale 1ns / 1ps

module sctt_mul (
    input  logic                         aclk,
    input  logic [sctt_pkg::MUL_A_W-1:0] mul_a,
    input  logic [sctt_pkg::MUL_B_W-1:0] mul_b,
    output logic [sctt_pkg::MUL_P_W-1:0] prod_reg
);
    import sctt_pkg::*;

    logic [MUL_P_W-1:0] prod_next;

    assign prod_next = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

// ===== sv/sctt_div.sv =====
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module sctt_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sctt_pkg::div_req_t           div_req,
    output logic [sctt_pkg::DIV_N_W-1:0] quo_reg,
    output logic                         done_reg
);
    import sctt_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic               busy_reg, busy_next, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next, den_reg, den_next;
    logic [DIV_N_W-1:0] quo_next;
    logic [DIV_D_W:0]   trial, diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_N_W-1]};
        diff      = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (div_req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_N_W);
            rem_next  = '0;
            quo_next  = div_req.num;
            den_next  = div_req.den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

endmodule

// ===== sv/sample_clock_timestamp_tracker_unit.sv =====
// top level: sequencer, segment state, error window and median search
// an anchor or early reject goes straight from idle to output; a late reject leaves after the sum check
// a continuous item also runs the median rank search over n entries, n = window fill after the push,
// then the smoothing step and the 64-step divider before output
// one item at a time: ready only while idle; a result may wait in the m_ output registers
// reset: synchronous active low, clears control state and loads register defaults;
// the error window ram is not cleared
`timescale 1ns / 1ps
`include "sample_clock_timestamp_tracker_unit_defines.svh"

module sample_clock_timestamp_tracker_unit #(
    parameter int WINDOW = sctt_pkg::DEF_WINDOW
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sctt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sctt_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sctt_pkg::SAMPLE_W-1:0]   s_start_sample,
    input  logic [sctt_pkg::SAMPLE_W-1:0]   s_stamp_micros,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sctt_pkg::OUT_W-1:0]      m_outcome,
    output logic signed [sctt_pkg::ERR_W-1:0] m_phase_error,
    output logic signed [sctt_pkg::ERR_W-1:0] m_median_error,
    output logic signed [sctt_pkg::ERR_W-1:0] m_filtered_error,
    output logic [sctt_pkg::SLOPE_W-1:0]    m_segment_slope,
    output logic [sctt_pkg::TIME_W-1:0]     m_segment_time,
    output logic [sctt_pkg::EPOCH_W-1:0]    m_epoch
);
    import sctt_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int ACC_W = SAMPLE_W + SLOPE_W + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_RND, S_SUM, S_ERR,
        S_RI, S_LI, S_RJ, S_CJ, S_RK, S_MED,
        S_EW0, S_EW1, S_EW2, S_EW3, S_EW4, S_EW5,
        S_DVS, S_DVW, S_OUT
    } state_t;

    // configuration
    logic [SLOPE_W-1:0] nominal_reg, slew_reg;
    logic [LOOK_W-1:0]  look_reg;
    logic [GAIN_W-1:0]  gain_reg, gain_wr;

    assign gain_wr = (cfg_wr_data[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE : cfg_wr_data[GAIN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nominal_reg <= NOMINAL_RST;
            look_reg    <= LOOK_RST;
            gain_reg    <= GAIN_RST;
            slew_reg    <= SLEW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NOMINAL: nominal_reg <= cfg_wr_data[SLOPE_W-1:0];
                CFG_LOOK:    look_reg    <= cfg_wr_data[LOOK_W-1:0];
                CFG_GAIN:    gain_reg    <= gain_wr;
                CFG_SLEW:    slew_reg    <= cfg_wr_data[SLOPE_W-1:0];
                default:     nominal_reg <= nominal_reg;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic anch_reg, anch_next, m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] last_reg, last_next, smp_reg, smp_next, delta_reg, delta_next;
    logic [TIME_W-1:0]   time_reg, time_next, obs_reg, obs_next, pred_reg, pred_next;
    logic [SLOPE_W-1:0]  slope_reg, slope_next;
    logic [CNT_W-1:0]    count_reg, count_next, i_reg, i_next, j_reg, j_next;
    logic [CNT_W-1:0]    rank_reg, rank_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic signed [ERR_W-1:0] smooth_reg, smooth_next, perr_reg, perr_next, med_reg, med_next;
    logic signed [ERR_W-1:0] cand_reg, cand_next, mlo_reg, mlo_next, mhi_reg, mhi_next;
    logic [EPOCH_W-1:0]  gen_reg, gen_next;
    logic [OUT_W-1:0]    outcome_reg, outcome_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ERR_W:0]      dm_reg, dm_next;
    logic                dneg_reg, dneg_next, fneg_reg, fneg_next;

    logic [OUT_W-1:0]        m_outcome_reg, m_outcome_next;
    logic signed [ERR_W-1:0] m_perr_reg, m_perr_next, m_med_reg, m_med_next;
    logic signed [ERR_W-1:0] m_filt_reg, m_filt_next;
    logic [SLOPE_W-1:0]      m_slope_reg, m_slope_next;
    logic [TIME_W-1:0]       m_time_reg, m_time_next;
    logic [EPOCH_W-1:0]      m_epoch_reg, m_epoch_next;

    // shared units
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;
    div_req_t           div_req;
    logic [DIV_N_W-1:0] div_quo;
    logic               div_done;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [ERR_W-1:0]   ram_wdata, ram_rdata;

    sctt_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod)
    );

    sctt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .div_req  (div_req),
        .quo_reg  (div_quo),
        .done_reg (div_done)
    );

    sctt_ram #(
        .WIDTH (ERR_W),
        .DEPTH (WINDOW),
        .AW    (IDX_W)
    ) u_window (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // datapath temporaries
    logic [TIME_W:0]     sum65;
    logic                eneg, rank_up;
    logic [TIME_W-1:0]   mag;
    logic signed [ERR_W-1:0] perr_sat, rd_err;
    logic [ERR_W:0]      med_sum, diff49;
    logic [ERR_W:0]      adj;
    logic [ERR_W-1:0]    fmag;
    logic [SLOPE_W-1:0]  am;
    logic [SLOPE_W:0]    slope_sum;
    logic [CNT_W-1:0]    half;

    assign s_ready = (state_reg == S_IDLE);
    assign half    = count_reg >> 1;
    assign rd_err  = $signed(ram_rdata);

    always_comb begin
        state_next   = state_reg;
        anch_next    = anch_reg;
        last_next    = last_reg;
        smp_next     = smp_reg;
        delta_next   = delta_reg;
        time_next    = time_reg;
        obs_next     = obs_reg;
        pred_next    = pred_reg;
        slope_next   = slope_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        rank_next    = rank_reg;
        smooth_next  = smooth_reg;
        perr_next    = perr_reg;
        med_next     = med_reg;
        cand_next    = cand_reg;
        mlo_next     = mlo_reg;
        mhi_next     = mhi_reg;
        gen_next     = gen_reg;
        outcome_next = outcome_reg;
        acc_next     = acc_reg;
        dm_next      = dm_reg;
        dneg_next    = dneg_reg;
        fneg_next    = fneg_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_outcome_next = m_outcome_reg;
        m_perr_next    = m_perr_reg;
        m_med_next     = m_med_reg;
        m_filt_next    = m_filt_reg;
        m_slope_next   = m_slope_reg;
        m_time_next    = m_time_reg;
        m_epoch_next   = m_epoch_reg;

        mul_a = '0;
        mul_b = '0;
        div_req.start = 1'b0;
        div_req.num   = {fmag, 16'b0};
        div_req.den   = delta_reg;
        ram_we    = 1'b0;
        ram_waddr = (count_reg < CNT_W'(WINDOW)) ? count_reg[IDX_W-1:0] : head_reg;
        ram_raddr = (state_reg == S_RI) ? i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];

        sum65    = {1'b0, time_reg} + {1'b0, acc_reg[TIME_W+15:16]};
        eneg     = obs_reg < pred_reg;
        mag      = eneg ? (pred_reg - obs_reg) : (obs_reg - pred_reg);
        if (eneg) begin
            perr_sat = (mag >= TIME_W'(64'h8000_0000_0000)) ? {1'b1, {(ERR_W-1){1'b0}}}
                                                           : -$signed(mag[ERR_W-1:0]);
        end else begin
            perr_sat = (mag > TIME_W'(64'h7FFF_FFFF_FFFF)) ? {1'b0, {(ERR_W-1){1'b1}}}
                                                          : $signed(mag[ERR_W-1:0]);
        end
        ram_wdata = perr_sat;
        rank_up   = (rd_err < cand_reg) || ((rd_err == cand_reg) && (j_reg < i_reg));
        med_sum   = {mlo_reg[ERR_W-1], mlo_reg} + {mhi_reg[ERR_W-1], mhi_reg};
        diff49    = {med_reg[ERR_W-1], med_reg} - {smooth_reg[ERR_W-1], smooth_reg};
        adj       = acc_reg[ERR_W+16:16];
        fmag      = smooth_reg[ERR_W-1] ? ERR_W'(-smooth_reg) : ERR_W'(smooth_reg);
        am        = (div_quo > DIV_N_W'(slew_reg)) ? slew_reg : div_quo[SLOPE_W-1:0];
        slope_sum = {1'b0, nominal_reg} + {1'b0, am};

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    smp_next = s_start_sample;
                    obs_next = {s_stamp_micros, 16'b0};
                    delta_next = s_start_sample - last_reg;
                    perr_next = '0;
                    med_next  = '0;
                    if (!anch_reg) begin
                        anch_next    = 1'b1;
                        gen_next     = EPOCH_W'(1);
                        last_next    = s_start_sample;
                        time_next    = {s_stamp_micros, 16'b0};
                        slope_next   = nominal_reg;
                        outcome_next = OUT_ANCHOR;
                        state_next   = S_OUT;
                    end else if (s_start_sample <= last_reg) begin
                        outcome_next = OUT_REJECT;
                        state_next   = S_OUT;
                    end else begin
                        state_next = S_M0;
                    end
                end
            end
            S_M0: begin
                mul_a = {1'b0, delta_reg[23:0]};
                mul_b = slope_reg;
                state_next = S_M1;
            end
            S_M1: begin
                mul_a = {1'b0, delta_reg[47:24]};
                mul_b = slope_reg;
                acc_next = ACC_W'(prod);
                state_next = S_M2;
            end
            S_M2: begin
                acc_next = acc_reg + (ACC_W'(prod) << 24);
                state_next = S_RND;
            end
            S_RND: begin
                acc_next = acc_reg + ACC_W'(ROUND_HALF);
                state_next = S_SUM;
            end
            S_SUM: begin
                if ((acc_reg[ACC_W-1:TIME_W+16] != '0) || sum65[TIME_W]) begin
                    outcome_next = OUT_REJECT;
                    state_next   = S_OUT;
                end else begin
                    pred_next  = sum65[TIME_W-1:0];
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                perr_next = perr_sat;
                last_next = smp_reg;
                if (mag > TIME_W'({look_reg, 16'b0})) begin
                    count_next   = '0;
                    head_next    = '0;
                    smooth_next  = '0;
                    gen_next     = gen_reg + EPOCH_W'(1);
                    time_next    = eneg ? pred_reg : obs_reg;
                    slope_next   = nominal_reg;
                    outcome_next = OUT_DISC;
                    state_next   = S_OUT;
                end else begin
                    ram_we    = 1'b1;
                    time_next = pred_reg;
                    if (count_reg < CNT_W'(WINDOW)) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        head_next = (head_reg == IDX_W'(WINDOW - 1)) ? '0
                                                                     : head_reg + IDX_W'(1);
                    end
                    i_next     = '0;
                    state_next = S_RI;
                end
            end
            S_RI: begin
                state_next = S_LI;
            end
            S_LI: begin
                cand_next  = rd_err;
                j_next     = '0;
                rank_next  = '0;
                state_next = S_RJ;
            end
            S_RJ: begin
                state_next = S_CJ;
            end
            S_CJ: begin
                if (rank_up) begin
                    rank_next = rank_reg + CNT_W'(1);
                end
                if (j_reg == count_reg - CNT_W'(1)) begin
                    state_next = S_RK;
                end else begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_RJ;
                end
            end
            S_RK: begin
                if (rank_reg == half) begin
                    mhi_next = cand_reg;
                end
                if (!count_reg[0] && (rank_reg == half - CNT_W'(1))) begin
                    mlo_next = cand_reg;
                end
                if (i_reg == count_reg - CNT_W'(1)) begin
                    state_next = S_MED;
                end else begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_RI;
                end
            end
            S_MED: begin
                med_next   = count_reg[0] ? mhi_reg : $signed(med_sum[ERR_W:1]);
                state_next = S_EW0;
            end
            S_EW0: begin
                dneg_next  = diff49[ERR_W];
                dm_next    = diff49[ERR_W] ? -diff49 : diff49;
                state_next = S_EW1;
            end
            S_EW1: begin
                mul_a = {1'b0, dm_reg[23:0]};
                mul_b = MUL_B_W'(gain_reg);
                state_next = S_EW2;
            end
            S_EW2: begin
                mul_a = dm_reg[ERR_W:24];
                mul_b = MUL_B_W'(gain_reg);
                acc_next = ACC_W'(prod);
                state_next = S_EW3;
            end
            S_EW3: begin
                acc_next = acc_reg + (ACC_W'(prod) << 24);
                state_next = S_EW4;
            end
            S_EW4: begin
                acc_next = acc_reg + ACC_W'(ROUND_HALF);
                state_next = S_EW5;
            end
            S_EW5: begin
                smooth_next = dneg_reg ? smooth_reg - $signed(adj[ERR_W-1:0])
                                       : smooth_reg + $signed(adj[ERR_W-1:0]);
                state_next = S_DVS;
            end
            S_DVS: begin
                fneg_next     = smooth_reg[ERR_W-1];
                div_req.start = 1'b1;
                state_next    = S_DVW;
            end
            S_DVW: begin
                if (div_done) begin
                    if (fneg_reg) begin
                        slope_next = (am > nominal_reg) ? '0 : nominal_reg - am;
                    end else begin
                        slope_next = slope_sum[SLOPE_W] ? '1 : slope_sum[SLOPE_W-1:0];
                    end
                    outcome_next = OUT_CONT;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_outcome_next = outcome_reg;
                    m_perr_next    = perr_reg;
                    m_med_next     = (outcome_reg == OUT_CONT) ? med_reg : '0;
                    m_filt_next    = smooth_reg;
                    m_slope_next   = slope_reg;
                    m_time_next    = time_reg;
                    m_epoch_next   = gen_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            anch_reg    <= 1'b0;
            last_reg    <= '0;
            time_reg    <= '0;
            slope_reg   <= '0;
            count_reg   <= '0;
            head_reg    <= '0;
            smooth_reg  <= '0;
            gen_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            anch_reg    <= anch_next;
            last_reg    <= last_next;
            time_reg    <= time_next;
            slope_reg   <= slope_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            smooth_reg  <= smooth_next;
            gen_reg     <= gen_next;
            m_valid_reg <= m_valid_next;
        end
        smp_reg       <= smp_next;
        delta_reg     <= delta_next;
        obs_reg       <= obs_next;
        pred_reg      <= pred_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        rank_reg      <= rank_next;
        perr_reg      <= perr_next;
        med_reg       <= med_next;
        cand_reg      <= cand_next;
        mlo_reg       <= mlo_next;
        mhi_reg       <= mhi_next;
        outcome_reg   <= outcome_next;
        acc_reg       <= acc_next;
        dm_reg        <= dm_next;
        dneg_reg      <= dneg_next;
        fneg_reg      <= fneg_next;
        m_outcome_reg <= m_outcome_next;
        m_perr_reg    <= m_perr_next;
        m_med_reg     <= m_med_next;
        m_filt_reg    <= m_filt_next;
        m_slope_reg   <= m_slope_next;
        m_time_reg    <= m_time_next;
        m_epoch_reg   <= m_epoch_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_outcome        = m_outcome_reg;
    assign m_phase_error    = m_perr_reg;
    assign m_median_error   = m_med_reg;
    assign m_filtered_error = m_filt_reg;
    assign m_segment_slope  = m_slope_reg;
    assign m_segment_time   = m_time_reg;
    assign m_epoch          = m_epoch_reg;

    `SCTT_ASSERT(a_count_range, count_reg <= CNT_W'(WINDOW), "window count beyond depth")
    `SCTT_ASSERT_IMP(a_head_full, head_reg != '0, count_reg == CNT_W'(WINDOW), "head moved early")
    `SCTT_ASSERT_IMP(a_med_zero, m_valid_reg && (m_outcome_reg != OUT_CONT), m_med_reg == '0, "median set on non continuous result")

endmodule
